/* rtl/stl_pkg.sv */
// Shared constants and character helpers of the streaming Scheme token lexer.
package stl_pkg;

  localparam int unsigned TypeBits = 3;
  localparam int unsigned ByteBits = 8;
  localparam int unsigned KwLen    = 6;

  localparam logic [TypeBits-1:0] TokEnd     = 3'd0;
  localparam logic [TypeBits-1:0] TokIdent   = 3'd1;
  localparam logic [TypeBits-1:0] TokKeyword = 3'd2;
  localparam logic [TypeBits-1:0] TokNumber  = 3'd3;
  localparam logic [TypeBits-1:0] TokString  = 3'd4;
  localparam logic [TypeBits-1:0] TokLparen  = 3'd5;
  localparam logic [TypeBits-1:0] TokRparen  = 3'd6;
  localparam logic [TypeBits-1:0] TokHash    = 3'd7;

  localparam logic [ByteBits-1:0] ChLparen  = 8'h28;
  localparam logic [ByteBits-1:0] ChRparen  = 8'h29;
  localparam logic [ByteBits-1:0] ChHash    = 8'h23;
  localparam logic [ByteBits-1:0] ChQuote   = 8'h22;
  localparam logic [ByteBits-1:0] ChSemi    = 8'h3B;
  localparam logic [ByteBits-1:0] ChNewline = 8'h0A;
  localparam logic [ByteBits-1:0] ChDot     = 8'h2E;

  // Characters of the keyword "define", indexed by match count.
  function automatic logic [ByteBits-1:0] kw_char(input logic [2:0] idx);
    logic [ByteBits-1:0] c;
    case (idx)
      3'd0:    c = 8'h64;
      3'd1:    c = 8'h65;
      3'd2:    c = 8'h66;
      3'd3:    c = 8'h69;
      3'd4:    c = 8'h6E;
      3'd5:    c = 8'h65;
      default: c = 8'h00;
    endcase
    return c;
  endfunction

  function automatic logic is_digit(input logic [ByteBits-1:0] b);
    return (b >= 8'h30) && (b <= 8'h39);
  endfunction

  function automatic logic is_letter(input logic [ByteBits-1:0] b);
    return ((b >= 8'h61) && (b <= 8'h7A)) || ((b >= 8'h41) && (b <= 8'h5A));
  endfunction

  function automatic logic is_ident_start(input logic [ByteBits-1:0] b);
    logic r;
    case (b)
      8'h21, 8'h24, 8'h25, 8'h26, 8'h2A, 8'h2B, 8'h2D, 8'h2F,
      8'h3A, 8'h3C, 8'h3D, 8'h3E, 8'h3F, 8'h5E, 8'h5F, 8'h7E: r = 1'b1;
      default: r = is_letter(b);
    endcase
    return r;
  endfunction

  function automatic logic is_ident_cont(input logic [ByteBits-1:0] b);
    return is_ident_start(b) || is_digit(b) || (b == ChDot);
  endfunction

endpackage

/* rtl/stl_if.sv */
// Handshake interfaces for the lexer's byte input and token output channels.
interface stl_in_if;
  logic                          valid;
  logic                          ready;
  logic                          kind;
  logic [stl_pkg::ByteBits-1:0]  text_byte;

  modport source (output valid, output kind, output text_byte, input ready);
  modport sink   (input valid, input kind, input text_byte, output ready);
endinterface

interface stl_out_if #(
  parameter int unsigned OFFSET_BITS = 16
);
  logic                          valid;
  logic                          ready;
  logic [stl_pkg::TypeBits-1:0]  token_type;
  logic [OFFSET_BITS-1:0]        token_start;
  logic [OFFSET_BITS:0]          token_end;
  logic                          last_token;
  logic                          position_overflow;

  modport source (output valid, output token_type, output token_start, output token_end,
                  output last_token, output position_overflow, input ready);
  modport sink   (input valid, input token_type, input token_start, input token_end,
                  input last_token, input position_overflow, output ready);
endinterface

/* rtl/scheme_token_lexer.sv */
// Streaming Scheme lexer: one source byte per item in, tokens with offsets out.
//
// Input channel text_i carries one item per byte (kind = 0) or the end of the
// text (kind = 1). Output channel token_o carries tokens with type, start and
// end offsets; the END token that closes a text has last_token set.
// A byte is classified against the scan state in the accepting cycle and the
// state is updated at that edge; the tokens it closes (zero, one or two) are
// written into a four-entry output queue, so a token is registered before it
// reaches the output. The lexer takes one byte per cycle while the queue has
// room for two tokens; a byte that closes two tokens is absorbed by the queue
// when the receiver keeps up. When the receiver stalls the queue fills and
// text_i.ready drops; nothing is lost. Reset empties the queue and returns
// the scan state to idle at offset zero. End offsets saturate at
// 2^OFFSET_BITS and start offsets at 2^OFFSET_BITS-1; position_overflow is
// raised from the first byte beyond that range until the END token.
module scheme_token_lexer #(
  parameter int unsigned OFFSET_BITS = 16
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  stl_in_if.sink    text_i,
  stl_out_if.source token_o
);

  localparam int unsigned PosBits = OFFSET_BITS + 1;

  typedef enum logic [2:0] {
    ModeIdle,
    ModeIdent,
    ModeNumber,
    ModeString,
    ModeComment
  } mode_e;

  typedef struct packed {
    logic [stl_pkg::TypeBits-1:0] ttype;
    logic [OFFSET_BITS-1:0]       start;
    logic [OFFSET_BITS:0]         stop;
    logic                         last;
    logic                         ovf;
  } tok_t;

  mode_e                  mode_q, mode_d;
  logic [PosBits-1:0]     pos_q, pos_d;
  logic [OFFSET_BITS-1:0] open_start_q, open_start_d;
  logic [2:0]             kw_cnt_q, kw_cnt_d;
  logic                   kw_mis_q, kw_mis_d;
  logic                   ovf_q, ovf_d;

  logic                   accept;
  logic [stl_pkg::ByteBits-1:0] b;
  logic [OFFSET_BITS-1:0] start_sat;
  logic [PosBits-1:0]     end_one;
  logic                   ovf_tok;
  logic                   close_vld, disp_vld;
  tok_t                   close_tok, disp_tok;
  logic                   ident_kw;

  // Output queue.
  tok_t       q_mem [4];
  logic [1:0] rd_ptr_q, wr_ptr_q;
  logic [2:0] cnt_q;
  logic       pop;
  logic [1:0] push_n;
  tok_t       wr0, wr1;

  assign accept    = text_i.valid && text_i.ready;
  assign text_i.ready = (cnt_q <= 3'd2);
  assign b         = text_i.text_byte;
  assign start_sat = pos_q[OFFSET_BITS] ? {OFFSET_BITS{1'b1}} : pos_q[OFFSET_BITS-1:0];
  assign end_one   = pos_q[OFFSET_BITS] ? pos_q : pos_q + PosBits'(1);
  assign ident_kw  = !kw_mis_q && (kw_cnt_q == 3'(stl_pkg::KwLen));

  always_comb begin
    mode_d       = mode_q;
    pos_d        = pos_q;
    open_start_d = open_start_q;
    kw_cnt_d     = kw_cnt_q;
    kw_mis_d     = kw_mis_q;
    ovf_d        = ovf_q;
    close_vld    = 1'b0;
    disp_vld     = 1'b0;
    ovf_tok      = ovf_q;
    close_tok    = '{ttype: stl_pkg::TokIdent, start: open_start_q, stop: pos_q,
                     last: 1'b0, ovf: 1'b0};
    disp_tok     = '{ttype: stl_pkg::TokEnd, start: start_sat, stop: end_one,
                     last: 1'b0, ovf: 1'b0};

    if (text_i.kind) begin
      // End of text: close what is open, then the END token; state resets.
      case (mode_q)
        ModeIdent: begin
          close_vld       = 1'b1;
          close_tok.ttype = ident_kw ? stl_pkg::TokKeyword : stl_pkg::TokIdent;
        end
        ModeNumber: begin
          close_vld       = 1'b1;
          close_tok.ttype = stl_pkg::TokNumber;
        end
        ModeString: begin
          close_vld       = 1'b1;
          close_tok.ttype = stl_pkg::TokString;
        end
        default: ;
      endcase
      disp_vld       = 1'b1;
      disp_tok.ttype = stl_pkg::TokEnd;
      disp_tok.stop  = pos_q;
      disp_tok.last  = 1'b1;
      mode_d         = ModeIdle;
      pos_d          = '0;
      open_start_d   = '0;
      kw_cnt_d       = '0;
      kw_mis_d       = 1'b0;
      ovf_d          = 1'b0;
    end else begin
      logic dispatch;
      dispatch = 1'b0;
      ovf_tok  = ovf_q | pos_q[OFFSET_BITS];
      ovf_d    = ovf_tok;
      pos_d    = end_one;
      case (mode_q)
        ModeIdent: begin
          if (stl_pkg::is_ident_cont(b)) begin
            if (!kw_mis_q && (kw_cnt_q < 3'(stl_pkg::KwLen))) begin
              if (b == stl_pkg::kw_char(kw_cnt_q)) kw_cnt_d = kw_cnt_q + 3'd1;
              else kw_mis_d = 1'b1;
            end
          end else begin
            close_vld       = 1'b1;
            close_tok.ttype = ident_kw ? stl_pkg::TokKeyword : stl_pkg::TokIdent;
            dispatch        = 1'b1;
          end
        end
        ModeNumber: begin
          if (!stl_pkg::is_digit(b)) begin
            close_vld       = 1'b1;
            close_tok.ttype = stl_pkg::TokNumber;
            dispatch        = 1'b1;
          end
        end
        ModeString: begin
          if (b == stl_pkg::ChQuote) begin
            close_vld       = 1'b1;
            close_tok.ttype = stl_pkg::TokString;
            close_tok.stop  = end_one;
            mode_d          = ModeIdle;
          end
        end
        ModeComment: begin
          if (b == stl_pkg::ChNewline) mode_d = ModeIdle;
        end
        default: dispatch = 1'b1;
      endcase

      // A byte that ends an identifier or number, or any byte in idle mode, starts afresh.
      if (dispatch) begin
        mode_d = ModeIdle;
        if (b == stl_pkg::ChLparen) begin
          disp_vld       = 1'b1;
          disp_tok.ttype = stl_pkg::TokLparen;
        end else if (b == stl_pkg::ChRparen) begin
          disp_vld       = 1'b1;
          disp_tok.ttype = stl_pkg::TokRparen;
        end else if (b == stl_pkg::ChHash) begin
          disp_vld       = 1'b1;
          disp_tok.ttype = stl_pkg::TokHash;
        end else if (b == stl_pkg::ChQuote) begin
          mode_d       = ModeString;
          open_start_d = start_sat;
        end else if (b == stl_pkg::ChSemi) begin
          mode_d = ModeComment;
        end else if (stl_pkg::is_digit(b)) begin
          mode_d       = ModeNumber;
          open_start_d = start_sat;
        end else if (stl_pkg::is_ident_start(b)) begin
          mode_d       = ModeIdent;
          open_start_d = start_sat;
          kw_mis_d     = (b != stl_pkg::kw_char(3'd0));
          kw_cnt_d     = kw_mis_d ? 3'd0 : 3'd1;
        end
      end
    end

    close_tok.ovf = ovf_tok;
    disp_tok.ovf  = ovf_tok;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q       <= ModeIdle;
      pos_q        <= '0;
      open_start_q <= '0;
      kw_cnt_q     <= '0;
      kw_mis_q     <= 1'b0;
      ovf_q        <= 1'b0;
    end else if (accept) begin
      mode_q       <= mode_d;
      pos_q        <= pos_d;
      open_start_q <= open_start_d;
      kw_cnt_q     <= kw_cnt_d;
      kw_mis_q     <= kw_mis_d;
      ovf_q        <= ovf_d;
    end
  end

  // Up to two tokens enter the queue per item, the closed token first.
  assign push_n = accept ? ({1'b0, close_vld} + {1'b0, disp_vld}) : 2'd0;
  assign wr0    = close_vld ? close_tok : disp_tok;
  assign wr1    = disp_tok;
  assign pop    = token_o.valid && token_o.ready;

  always_ff @(posedge clk_i) begin
    if (push_n != 2'd0) q_mem[wr_ptr_q] <= wr0;
    if (push_n == 2'd2) q_mem[wr_ptr_q + 2'd1] <= wr1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_ptr_q <= '0;
      wr_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_q + push_n;
      rd_ptr_q <= rd_ptr_q + {1'b0, pop};
      cnt_q    <= cnt_q + {1'b0, push_n} - {2'b00, pop};
    end
  end

  assign token_o.valid             = (cnt_q != 3'd0);
  assign token_o.token_type        = q_mem[rd_ptr_q].ttype;
  assign token_o.token_start       = q_mem[rd_ptr_q].start;
  assign token_o.token_end         = q_mem[rd_ptr_q].stop;
  assign token_o.last_token        = q_mem[rd_ptr_q].last;
  assign token_o.position_overflow = q_mem[rd_ptr_q].ovf;

endmodule
